// ===== sv/kdd_pkg.sv =====
// Shared types and constants for the keyed dedup keep-max block.
`timescale 1ns / 1ps
`default_nettype none
package kdd_pkg;

   localparam int COORD_W  = 31;
   localparam int LENGTH_W = 24;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [COORD_W-1:0]  rec_start;
      logic [COORD_W-1:0]  rec_end;
      logic [LENGTH_W-1:0] rec_length;
   } kdd_req_type;

   typedef struct packed {
      logic [COORD_W-1:0]  out_start;
      logic [COORD_W-1:0]  out_end;
      logic [LENGTH_W-1:0] out_length;
      logic                last;
      logic                overflow;
   } kdd_rsp_type;

   // One stored table entry.
   typedef struct packed {
      logic [COORD_W-1:0]  start;
      logic [COORD_W-1:0]  stop;
      logic [LENGTH_W-1:0] length;
   } kdd_entry_type;

   localparam int ENTRY_W = $bits(kdd_entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FLUSH
   } kdd_state_type;

   // Result load request from the controller to the output register.
   typedef struct packed {
      logic load;
      logic last;
      logic overflow;
   } kdd_emit_type;

   // Controller status seen by the top level.
   typedef struct packed {
      logic busy;
      logic table_empty;
      logic tail_valid;
      logic overflow;
   } kdd_status_type;

endpackage
`default_nettype wire

// ===== sv/kdd_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kdd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // hold read data while no read is issued
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== sv/kdd_ctrl.sv =====
// Search, append and flush sequencer with valid bits and fill count.
`timescale 1ns / 1ps
`default_nettype none
module kdd_ctrl #(
   parameter int TABLE_DEPTH = 32,
   parameter int IDX_W       = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire kdd_pkg::kdd_req_type   req_data,
   input  wire kdd_pkg::kdd_entry_type rd_data,
   input  wire logic                   out_free,
   output logic                        ram_re,
   output logic [IDX_W-1:0]            ram_raddr,
   output logic                        ram_we,
   output logic [IDX_W-1:0]            ram_waddr,
   output kdd_pkg::kdd_entry_type      ram_wdata,
   output kdd_pkg::kdd_emit_type       emit,
   output kdd_pkg::kdd_status_type     status
);
   import kdd_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   kdd_state_type          state_ff, state_in;
   logic [CNT_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                   chk_pend_ff, chk_pend_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic                   ovf_ff, ovf_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   kdd_entry_type          rec_ff, rec_in;

   logic             more;
   logic             match;
   logic             longer;
   logic             emit_vld;
   logic [CNT_W-1:0] tail_cnt;

   assign more     = rd_ptr_ff < fill_ff;
   assign match    = chk_pend_ff && valid_ff[chk_idx_ff]
                     && rd_data.start == rec_ff.start && rd_data.stop == rec_ff.stop;
   assign longer   = rd_data.length > rec_ff.length;
   assign emit_vld = chk_pend_ff && valid_ff[chk_idx_ff];
   assign tail_cnt = fill_ff - ONE_CNT;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_ptr_ff   <= '0;
         chk_pend_ff <= 1'b0;
         fill_ff     <= '0;
         ovf_ff      <= 1'b0;
         valid_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         rd_ptr_ff   <= rd_ptr_in;
         chk_pend_ff <= chk_pend_in;
         fill_ff     <= fill_in;
         ovf_ff      <= ovf_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      rec_ff     <= rec_in;
   end

   always_comb begin
      state_in    = state_ff;
      rd_ptr_in   = rd_ptr_ff;
      chk_pend_in = chk_pend_ff;
      chk_idx_in  = chk_idx_ff;
      fill_in     = fill_ff;
      ovf_in      = ovf_ff;
      valid_in    = valid_ff;
      rec_in      = rec_ff;
      ram_re      = 1'b0;
      ram_raddr   = rd_ptr_ff[IDX_W-1:0];
      ram_we      = 1'b0;
      ram_waddr   = fill_ff[IDX_W-1:0];
      ram_wdata   = rec_ff;
      emit        = '0;

      case (state_ff)
         ST_IDLE: begin
            chk_pend_in = 1'b0;
            rd_ptr_in   = '0;
            if (req_valid) begin
               rec_in.start  = req_data.rec_start;
               rec_in.stop   = req_data.rec_end;
               rec_in.length = req_data.rec_length;
               if (req_data.operation == OP_FLUSH) begin
                  // empty group: only drop the overflow mark
                  if (fill_ff == '0) begin
                     ovf_in = 1'b0;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end else if (fill_ff == FULL_CNT) begin
                  ovf_in = 1'b1;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (match && longer) begin
               // kept record is longer: drop the new one
               chk_pend_in = 1'b0;
               state_in    = ST_IDLE;
            end else begin
               if (match) begin
                  valid_in[chk_idx_ff] = 1'b0;
               end
               if (more) begin
                  ram_re      = 1'b1;
                  rd_ptr_in   = rd_ptr_ff + ONE_CNT;
                  chk_pend_in = 1'b1;
                  chk_idx_in  = rd_ptr_ff[IDX_W-1:0];
               end else begin
                  ram_we                          = 1'b1;
                  valid_in[fill_ff[IDX_W-1:0]]    = 1'b1;
                  fill_in                         = fill_ff + ONE_CNT;
                  chk_pend_in                     = 1'b0;
                  state_in                        = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            emit.load     = emit_vld && out_free;
            emit.last     = chk_idx_ff == tail_cnt[IDX_W-1:0];
            emit.overflow = ovf_ff;
            // advance unless a live entry waits for the output register
            if (!emit_vld || out_free) begin
               if (more) begin
                  ram_re      = 1'b1;
                  rd_ptr_in   = rd_ptr_ff + ONE_CNT;
                  chk_pend_in = 1'b1;
                  chk_idx_in  = rd_ptr_ff[IDX_W-1:0];
               end else begin
                  chk_pend_in = 1'b0;
                  valid_in    = '0;
                  fill_in     = '0;
                  ovf_in      = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign status.busy        = state_ff != ST_IDLE;
   assign status.table_empty = fill_ff == '0;
   assign status.tail_valid  = valid_ff[tail_cnt[IDX_W-1:0]];
   assign status.overflow    = ovf_ff;

endmodule
`default_nettype wire

// ===== sv/keyed_dedup_keep_max_top.sv =====
// Top level of the keyed dedup keep-max block: table RAM, sequencer, result register.
// Add beat: stall while each filled slot is read and compared in turn, the last compare
// with the append write; the search ends early when a longer kept record matches, no stall when full.
// Flush beat: busy while each filled slot is read out, plus result stall; an empty table only clears overflow.
// Next beat is taken the cycle the stall drops.
// Reset clears valid bits, fill count, overflow mark and result valid; RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module keyed_dedup_keep_max_top #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire kdd_pkg::kdd_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output kdd_pkg::kdd_rsp_type      rsp_data
);
   import kdd_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Table RAM ports, driven by the sequencer.
   logic             ram_re;
   logic [IDX_W-1:0] ram_raddr;
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   kdd_entry_type    ram_wdata;
   kdd_entry_type    rd_entry;

   kdd_emit_type   emit;
   kdd_status_type status;

   // Result register: holds one beat so the sequencer runs on while it waits.
   logic        rsp_valid_ff, rsp_valid_in;
   kdd_rsp_type rsp_data_ff;
   logic        out_free;

   kdd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH),
      .AW    (IDX_W)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_entry)
   );

   kdd_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rd_data   (rd_entry),
      .out_free  (out_free),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .emit      (emit),
      .status    (status)
   );

   // Take new requests only while the sequencer is idle.
   assign req_stall = status.busy;

   // Free when empty or when the waiting beat leaves this cycle.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = emit.load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load payload straight from the RAM read register.
   always_ff @(posedge clock) begin
      if (emit.load) begin
         rsp_data_ff.out_start  <= rd_entry.start;
         rsp_data_ff.out_end    <= rd_entry.stop;
         rsp_data_ff.out_length <= rd_entry.length;
         rsp_data_ff.last       <= emit.last;
         rsp_data_ff.overflow   <= emit.overflow;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // The newest appended entry stays valid; the last flag depends on it.
   a_tail_valid: assert property (@(posedge clock) disable iff (reset)
      !status.table_empty |-> status.tail_valid)
      else $error("tail entry of a non-empty table is not valid");

   // Never overwrite a result beat that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit.load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   // A flush beat either starts a walk or leaves an empty, clean table.
   a_flush_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.operation == OP_FLUSH) |=>
      (status.busy || (status.table_empty && !status.overflow)))
      else $error("flush beat left table state behind");
`endif

endmodule
`default_nettype wire
